// ===== hdl/led_frame_rotate_and_pack_assert.svh =====
// assertion macros used by the checker module
`ifndef LED_FRAME_ROTATE_AND_PACK_ASSERT_SVH
`define LED_FRAME_ROTATE_AND_PACK_ASSERT_SVH

// same-cycle implication
`define LFRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lfrp_pkg.sv =====
`default_nettype none

package lfrp_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE     = 2'd0;
  localparam logic [1:0] REQ_ROT_POS   = 2'd1;
  localparam logic [1:0] REQ_ROT_COLOR = 2'd2;
  localparam logic [1:0] REQ_REFRESH   = 2'd3;

  // rotate sense
  localparam logic DIR_CCW = 1'b0;
  localparam logic DIR_CW  = 1'b1;

  // largest level that maps to a single bit
  localparam logic [3:0] LEVEL_ONE_HOT_MAX = 4'd12;
  localparam logic [11:0] GRAY_FULL = 12'hfff;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] led_index;
    logic [1:0] color_index;
    logic [3:0] level;
    logic       direction;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // operations applied to the level store
  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_WRITE,
    SOP_ROT_CCW,
    SOP_ROT_CW,
    SOP_ROT_COLOR,
    SOP_SHIFT
  } store_op_t;

  typedef struct packed {
    store_op_t  op;
    logic [2:0] led_index;
    logic [1:0] color_index;
    logic [3:0] level;
  } store_ctl_t;

  // byte position within a packed channel pair
  typedef enum logic [1:0] {
    PH_HI,
    PH_MID,
    PH_LO
  } phase_t;

  // level to 12-bit grayscale word
  function automatic logic [11:0] gray12(input logic [3:0] lv);
    logic [11:0] g;
    if (lv == 4'd0) begin
      g = 12'h000;
    end else if (lv > LEVEL_ONE_HOT_MAX) begin
      g = GRAY_FULL;
    end else begin
      g = 12'h001 << (lv - 4'd1);
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lfrp_store.sv =====
`default_nettype none

module lfrp_store #(
  parameter int NUM_LEDS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfrp_pkg::store_ctl_t ctl,
  output logic [3:0]          top_level
);
  import lfrp_pkg::*;

  localparam int NUM_CHAN = 3 * NUM_LEDS;

  logic [3:0] lvl_r   [NUM_CHAN];
  logic [3:0] lvl_nxt [NUM_CHAN];
  logic       wr_ok;

  // write target check
  assign wr_ok = (int'(ctl.led_index) < NUM_LEDS) && (ctl.color_index != 2'd3);

  // the refresh walk reads the highest channel
  assign top_level = lvl_r[NUM_CHAN-1];

  // next store contents
  always_comb begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      lvl_nxt[j] = lvl_r[j];
    end
    unique case (ctl.op)
      SOP_NONE: begin
      end
      SOP_WRITE: begin
        for (int j = 0; j < NUM_CHAN; j++) begin
          if (wr_ok && (j == 3 * int'(ctl.led_index) + int'(ctl.color_index))) begin
            lvl_nxt[j] = ctl.level;
          end
        end
      end
      SOP_ROT_CCW: begin
        for (int j = 0; j < NUM_CHAN; j++) begin
          lvl_nxt[j] = lvl_r[(j + 3 < NUM_CHAN) ? j + 3 : j + 3 - NUM_CHAN];
        end
      end
      SOP_ROT_CW: begin
        for (int j = 0; j < NUM_CHAN; j++) begin
          lvl_nxt[j] = lvl_r[(j >= 3) ? j - 3 : j - 3 + NUM_CHAN];
        end
      end
      SOP_ROT_COLOR: begin
        for (int n = 0; n < NUM_LEDS; n++) begin
          lvl_nxt[3*n]   = lvl_r[3*n+1];
          lvl_nxt[3*n+1] = lvl_r[3*n+2];
          lvl_nxt[3*n+2] = lvl_r[3*n];
        end
      end
      SOP_SHIFT: begin
        // circular shift up by one channel, restored after a full walk
        for (int j = 0; j < NUM_CHAN; j++) begin
          lvl_nxt[j] = lvl_r[(j >= 1) ? j - 1 : NUM_CHAN - 1];
        end
      end
      default: begin
      end
    endcase
  end

  // store registers
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      if (!rst_n) begin
        lvl_r[j] <= 4'd0;
      end else begin
        lvl_r[j] <= lvl_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfrp_pack.sv =====
`default_nettype none

module lfrp_pack (
  input  logic             clk,
  input  logic             step,
  input  lfrp_pkg::phase_t phase,
  input  logic             take_b,
  input  logic [3:0]       top_level,
  output logic [7:0]       pack_byte
);
  import lfrp_pkg::*;

  logic [11:0] gray;
  logic [11:0] gray_b;
  logic [3:0]  a_lo_r, a_lo_nxt;
  logic [7:0]  b_lo_r, b_lo_nxt;

  // shared level mapping
  assign gray   = gray12(top_level);
  assign gray_b = take_b ? gray : 12'h000;

  // byte select per phase
  always_comb begin
    a_lo_nxt = a_lo_r;
    b_lo_nxt = b_lo_r;
    case (phase)
      PH_HI: begin
        pack_byte = gray[11:4];
        a_lo_nxt  = gray[3:0];
      end
      PH_MID: begin
        pack_byte = {a_lo_r, gray_b[11:8]};
        b_lo_nxt  = gray_b[7:0];
      end
      PH_LO: begin
        pack_byte = b_lo_r;
      end
      default: begin
        pack_byte = 8'h00;
      end
    endcase
  end

  // held low parts of the pair
  always_ff @(posedge clk) begin
    if (step) begin
      a_lo_r <= a_lo_nxt;
      b_lo_r <= b_lo_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_frame_rotate_and_pack.sv =====
// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_stall | lfrp_pkg::in_item_t
// out_    | output    | out_valid/out_stall | lfrp_pkg::out_item_t
//
// Writes and rotations are applied to the store at their transfer.
// A refresh emits one byte per cycle while the output is not stalled,
// from the shared mapping and packing unit.
// in_stall is high while a refresh walks the store; out_stall holds the sequencer.
// Synchronous active-low reset clears the level store and all control state.
`default_nettype none

module led_frame_rotate_and_pack #(
  parameter int NUM_LEDS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfrp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lfrp_pkg::out_item_t out_data
);
  import lfrp_pkg::*;

  localparam int NUM_CHAN = 3 * NUM_LEDS;
  localparam int CW       = $clog2(NUM_CHAN + 1);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   chan_r, chan_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  store_ctl_t      ctl;
  logic [3:0]      top_level;
  logic [7:0]      pack_byte;
  logic            in_xfer;
  logic            out_free;
  logic            step;
  logic            take_ch;
  logic            take_b;
  logic            last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign step      = (state_r == ST_BUSY) && out_free;
  assign take_b    = (chan_r != '0);
  assign take_ch   = step && ((phase_r == PH_HI) || ((phase_r == PH_MID) && take_b));
  assign last      = (phase_r == PH_LO) && (chan_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // store operation select
  always_comb begin
    ctl.op          = SOP_NONE;
    ctl.led_index   = in_data.led_index;
    ctl.color_index = in_data.color_index;
    ctl.level       = in_data.level;
    if (in_xfer) begin
      unique case (in_data.req_type)
        REQ_WRITE:     ctl.op = SOP_WRITE;
        REQ_ROT_POS:   ctl.op = (in_data.direction == DIR_CW) ? SOP_ROT_CW : SOP_ROT_CCW;
        REQ_ROT_COLOR: ctl.op = SOP_ROT_COLOR;
        REQ_REFRESH:   ctl.op = SOP_NONE;
        default:       ctl.op = SOP_NONE;
      endcase
    end else if (take_ch) begin
      ctl.op = SOP_SHIFT;
    end
  end

  lfrp_store #(
    .NUM_LEDS (NUM_LEDS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .top_level (top_level)
  );

  lfrp_pack u_pack (
    .clk       (clk),
    .step      (step),
    .phase     (phase_r),
    .take_b    (take_b),
    .top_level (top_level),
    .pack_byte (pack_byte)
  );

  // refresh sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    chan_nxt      = chan_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.req_type == REQ_REFRESH)) begin
          state_nxt = ST_BUSY;
          phase_nxt = PH_HI;
          chan_nxt  = CW'(NUM_CHAN);
        end
      end
      ST_BUSY: begin
        if (step) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_byte  = pack_byte;
          out_data_nxt.last_byte = last;
          if (take_ch) begin
            chan_nxt = chan_r - CW'(1);
          end
          unique case (phase_r)
            PH_HI:  phase_nxt = PH_MID;
            PH_MID: phase_nxt = PH_LO;
            PH_LO: begin
              phase_nxt = PH_HI;
              if (last) begin
                state_nxt = ST_IDLE;
              end
            end
            default: phase_nxt = PH_HI;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HI;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/lfrp_checker.sv =====
`default_nettype none
`include "led_frame_rotate_and_pack_assert.svh"

module lfrp_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lfrp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lfrp_pkg::out_item_t out_data
);
  import lfrp_pkg::*;

  // a refresh transfer makes the block busy
  `LFRP_ASSERT_NEXT(a_refresh_busy, in_valid && !in_stall && (in_data.req_type == REQ_REFRESH), in_stall, "refresh did not hold off input")

  // a non-final byte means the walk is still running
  `LFRP_ASSERT_NOW(a_mid_walk_busy, out_valid && !out_data.last_byte, in_stall, "input open mid refresh")

  // store-only requests create no bytes
  `LFRP_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && !out_valid && (in_data.req_type != REQ_REFRESH), !out_valid, "byte from a non-refresh request")

  // a stalled byte holds
  `LFRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output changed")

endmodule

bind led_frame_rotate_and_pack lfrp_checker u_lfrp_checker (.*);

`default_nettype wire

// ===== bench/led_frame_rotate_and_pack_tb.sv =====
module led_frame_rotate_and_pack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrp_pkg::*;

  localparam int NUM_LEDS = 8;
  localparam int NUM_CHAN = 3 * NUM_LEDS;
  // settling margin after the predicted bytes have drained
  localparam int REFRESH_CYCLES = 45;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  // channel codes within one led
  localparam logic [1:0] COLOR_BLUE  = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_GREEN = 2'd2;
  localparam logic [1:0] COLOR_BAD   = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  // predicted frame and the bytes still owed by the block
  logic [3:0] frame_level [NUM_CHAN] = '{default: 4'h0};
  out_item_t  pending_bytes [$];

  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int hold_left = 0;
  int stall_run = 0;
  int stall_pct = 0;

  led_frame_rotate_and_pack #(
    .NUM_LEDS(NUM_LEDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // level to 12-bit grayscale word
  function automatic logic [11:0] level_to_gray(input logic [3:0] lv);
    logic [11:0] g;
    g = '0;
    if (lv > LEVEL_ONE_HOT_MAX) begin
      g = GRAY_FULL;
    end else if (lv != 4'd0) begin
      g[lv - 4'd1] = 1'b1;
    end
    return g;
  endfunction

  // apply one request to the predicted frame, queue the bytes of a refresh
  function automatic void track_request(input in_item_t item);
    logic [3:0]  prev [NUM_CHAN];
    logic [11:0] hi_word;
    logic [11:0] lo_word;
    out_item_t   tail;
    int          n;
    int          c;
    int          f;
    prev = frame_level;
    case (item.req_type)
      REQ_WRITE: begin
        if (item.led_index < NUM_LEDS && item.color_index != COLOR_BAD) begin
          frame_level[3 * item.led_index + item.color_index] = item.level;
        end
      end
      REQ_ROT_POS: begin
        for (n = 0; n < NUM_LEDS; n++) begin
          for (c = 0; c < 3; c++) begin
            if (item.direction == DIR_CW) begin
              frame_level[3 * n + c] = prev[3 * ((n + NUM_LEDS - 1) % NUM_LEDS) + c];
            end else begin
              frame_level[3 * n + c] = prev[3 * ((n + 1) % NUM_LEDS) + c];
            end
          end
        end
      end
      REQ_ROT_COLOR: begin
        for (n = 0; n < NUM_LEDS; n++) begin
          frame_level[3 * n]     = prev[3 * n + 1];
          frame_level[3 * n + 1] = prev[3 * n + 2];
          frame_level[3 * n + 2] = prev[3 * n];
        end
      end
      default: begin
        // walk pairs from the top channel down, missing lower word packs as zero
        for (f = NUM_CHAN - 1; f >= 0; f -= 2) begin
          hi_word = level_to_gray(frame_level[f]);
          lo_word = (f >= 1) ? level_to_gray(frame_level[f - 1]) : 12'h000;
          pending_bytes.push_back(out_item_t'{hi_word[11:4], 1'b0});
          pending_bytes.push_back(out_item_t'{{hi_word[3:0], lo_word[11:8]}, 1'b0});
          pending_bytes.push_back(out_item_t'{lo_word[7:0], 1'b0});
        end
        tail = pending_bytes.pop_back();
        tail.last_byte = 1'b1;
        pending_bytes.push_back(tail);
      end
    endcase
  endfunction

  // compare one output transfer with the oldest predicted byte
  function automatic void check_byte(input out_item_t got);
    out_item_t want;
    if (pending_bytes.size() == 0) begin
      $error("unexpected byte: out_byte %h last_byte %b", got.out_byte, got.last_byte);
      fail_count++;
    end else begin
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %b, actual %b", want.last_byte, got.last_byte);
        fail_count++;
      end
    end
  endfunction

  // output check first: nothing accepted at this edge can already show a byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_byte(out_data);
      end
      if (in_valid && !in_stall) begin
        track_request(in_data);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver stall pattern: runs of varying stall density, or a long hold
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_run = $urandom_range(8, 64);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_run--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic in_item_t make_item(input logic [1:0] req, input logic [2:0] led,
                                         input logic [1:0] color, input logic [3:0] lv,
                                         input logic dir);
    in_item_t item;
    item.req_type    = req;
    item.led_index   = led;
    item.color_index = color;
    item.level       = lv;
    item.direction   = dir;
    return item;
  endfunction

  function automatic in_item_t random_request();
    in_item_t item;
    int       pick;
    item = make_item(REQ_WRITE, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 2)),
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 7) == 0) begin
        item.color_index = COLOR_BAD;
      end
    end else if (pick < 62) begin
      item.req_type = REQ_ROT_POS;
      item.color_index = 2'($urandom_range(0, 3));
    end else if (pick < 75) begin
      item.req_type = REQ_ROT_COLOR;
      item.color_index = 2'($urandom_range(0, 3));
    end else begin
      item.req_type = REQ_REFRESH;
      item.color_index = 2'($urandom_range(0, 3));
    end
    return item;
  endfunction

  // one input transfer, with sender gaps between bursts
  task automatic send_item(input in_item_t item);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (!(in_valid && !in_stall));
  endtask

  // sender pauses until every predicted byte has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (REFRESH_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_frame();
    send_item(make_item(REQ_REFRESH, 3'd0, COLOR_BLUE, 4'd0, DIR_CCW));
  endtask

  // level extremes at both ends of the frame, plus an ignored channel code
  task automatic test_level_mapping();
    send_item(make_item(REQ_WRITE, 3'd7, COLOR_GREEN, 4'd15, DIR_CCW));
    send_item(make_item(REQ_WRITE, 3'd7, COLOR_RED, 4'd13, DIR_CW));
    send_item(make_item(REQ_WRITE, 3'd7, COLOR_BLUE, 4'd12, DIR_CCW));
    send_item(make_item(REQ_WRITE, 3'd6, COLOR_GREEN, 4'd1, DIR_CW));
    send_item(make_item(REQ_WRITE, 3'd6, COLOR_RED, 4'd7, DIR_CCW));
    send_item(make_item(REQ_WRITE, 3'd0, COLOR_BLUE, 4'd1, DIR_CCW));
    send_item(make_item(REQ_WRITE, 3'd0, COLOR_GREEN, 4'd10, DIR_CW));
    send_item(make_item(REQ_WRITE, 3'd5, COLOR_BAD, 4'd15, DIR_CW));
    send_item(make_item(REQ_REFRESH, 3'd7, COLOR_BAD, 4'd15, DIR_CW));
  endtask

  // wraparound in both senses and the channel cycle
  task automatic test_rotations();
    send_item(make_item(REQ_ROT_POS, 3'd0, COLOR_BLUE, 4'd0, DIR_CCW));
    send_item(make_item(REQ_REFRESH, 3'd0, COLOR_BLUE, 4'd0, DIR_CCW));
    send_item(make_item(REQ_ROT_POS, 3'd7, COLOR_GREEN, 4'd15, DIR_CW));
    send_item(make_item(REQ_ROT_POS, 3'd2, COLOR_RED, 4'd5, DIR_CW));
    send_item(make_item(REQ_REFRESH, 3'd5, COLOR_RED, 4'd9, DIR_CW));
    send_item(make_item(REQ_ROT_COLOR, 3'd1, COLOR_BAD, 4'd3, DIR_CCW));
    send_item(make_item(REQ_REFRESH, 3'd0, COLOR_BLUE, 4'd0, DIR_CCW));
  endtask

  // receiver holds off while the sender keeps offering, input backs up
  task automatic test_output_hold();
    int i;
    send_item(make_item(REQ_REFRESH, 3'd0, COLOR_BLUE, 4'd0, DIR_CCW));
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 6; i++) begin
      send_item(make_item(REQ_WRITE, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 2)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    send_item(make_item(REQ_REFRESH, 3'd0, COLOR_BLUE, 4'd0, DIR_CCW));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    in_item_t item;
    int       done;
    done = 0;
    while (done < count) begin
      item = random_request();
      send_item(item);
      if (!(item.req_type == REQ_WRITE && item.color_index == COLOR_BAD)) begin
        done++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_frame();
    test_level_mapping();
    test_rotations();
    drain_results();
    test_output_hold();
    test_random_traffic(50);
    drain_results();
    test_random_traffic(50);
    drain_results();
    test_random_traffic(50);
    drain_results();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
